### rtl/otss_pkg.sv
// shared constants, event codes and pulse width conversion for the servo sweep block
package otss_pkg;

    localparam int unsigned FUNC_W  = 2;
    localparam int unsigned TIME_W  = 16;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned CIDX_W  = 2;
    localparam int unsigned ANGLE_W = 8;
    localparam int unsigned PULSE_W = 11;

    localparam logic [FUNC_W-1:0] FUNC_CAPTURE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_OVERCAP = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd2;

    localparam logic [CIDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_DELAY     = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_TOP       = 2'd2;

    localparam logic [CFG_W-1:0] THRESHOLD_RST = 16'd2000;
    localparam logic [CFG_W-1:0] DELAY_RST     = 16'd200;
    localparam logic [CFG_W-1:0] TOP_RST       = 16'hFFFF;

    localparam logic [ANGLE_W-1:0] ANGLE_MAX = 8'd180;
    localparam logic [PULSE_W-1:0] PULSE_MIN = 11'd1000;
    localparam logic [PULSE_W-1:0] PULSE_MAX = 11'd2000;

    // 1000/180 scaled by 2^16, taken slightly high so the floor stays exact over 0..180
    localparam logic [18:0] PULSE_RECIP = 19'd364100;
    localparam int unsigned PULSE_SHIFT = 16;

    function automatic logic [PULSE_W-1:0] pulse_of(input logic [ANGLE_W-1:0] angle);
        logic [ANGLE_W-1:0] a;
        logic [26:0]        prod;
        a    = (angle > ANGLE_MAX) ? ANGLE_MAX : angle;
        prod = 27'(a) * 27'(PULSE_RECIP);
        return PULSE_MIN + PULSE_W'(prod >> PULSE_SHIFT);
    endfunction

endpackage

### rtl/occupancy_timed_servo_sweep_core.sv
// seat occupancy timer with delayed servo sweep: top level
//
// Usage
//   in channel  : in_valid/in_ready with func, capture_time and sensor_level.
//                 func selects capture edge, overcapture or servo period tick;
//                 any other code leaves the state alone and still gives a result.
//   out channel : out_valid/out_ready with red_led, blue_led, pulse_width,
//                 sweep_active and occupied; every input transfer yields one result.
//   cfg channel : cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 is the
//                 sit threshold, 1 the flush delay in ticks, 2 the counter top.
//                 cfg_ready is always high; write only while the block is idle.
// Timing
//   one input register and one result register; an item passes through them in
//   that order, and one item can be taken every cycle while out_ready is high.
//   the state update happens in the cycle the item moves from the input
//   register to the result register.
// Reset
//   rst_n clears block state and valid flags, loads register defaults; no clearing pass.
// Stall
//   while out_ready is low the result holds; the input register still takes
//   one more item, then in_ready drops until the result is taken.
module occupancy_timed_servo_sweep_core
    import otss_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic [FUNC_W-1:0]  func,
    input  logic [TIME_W-1:0]  capture_time,
    input  logic               sensor_level,

    output logic               out_valid,
    input  logic               out_ready,
    output logic               red_led,
    output logic               blue_led,
    output logic [PULSE_W-1:0] pulse_width,
    output logic               sweep_active,
    output logic               occupied,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]   cfg_data
);

    // configuration
    logic [CFG_W-1:0] threshold_reg;
    logic [CFG_W-1:0] delay_cfg_reg;
    logic [CFG_W-1:0] top_reg;

    // input stage
    logic              in_valid_reg;
    logic [FUNC_W-1:0] func_reg;
    logic [TIME_W-1:0] time_reg;
    logic              level_reg;

    // block state
    logic               sitting_reg,     sitting_next;
    logic [TIME_W-1:0]  sit_start_reg,   sit_start_next;
    logic [ANGLE_W-1:0] angle_reg,       angle_next;
    logic               moving_down_reg, moving_down_next;
    logic               sweep_on_reg,    sweep_on_next;
    logic               reached_top_reg, reached_top_next;
    logic [CFG_W-1:0]   delay_left_reg,  delay_left_next;
    logic               red_on_reg,      red_on_next;
    logic               blue_on_reg,     blue_on_next;

    // result stage
    logic               out_valid_reg;
    logic               out_red_reg;
    logic               out_blue_reg;
    logic [ANGLE_W-1:0] out_angle_reg;
    logic               out_sweep_reg;
    logic               out_sitting_reg;

    logic              advance;
    logic [17:0]       wrap_sum;
    logic [16:0]       elapsed;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RST;
            delay_cfg_reg <= DELAY_RST;
            top_reg       <= TOP_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_THRESHOLD: threshold_reg <= cfg_data;
                CFG_DELAY:     delay_cfg_reg <= cfg_data;
                CFG_TOP:       top_reg       <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            func_reg  <= func;
            time_reg  <= capture_time;
            level_reg <= sensor_level;
        end
    end

    // elapsed sit time with wrap correction, saturating at zero
    always_comb
    begin
        wrap_sum = 18'(top_reg) + 18'd1 + 18'(time_reg);
        if (time_reg >= sit_start_reg)
            elapsed = {1'b0, time_reg - sit_start_reg};
        else if (wrap_sum >= 18'(sit_start_reg))
            elapsed = 17'(wrap_sum - 18'(sit_start_reg));
        else
            elapsed = '0;
    end

    always_comb
    begin
        sitting_next     = sitting_reg;
        sit_start_next   = sit_start_reg;
        angle_next       = angle_reg;
        moving_down_next = moving_down_reg;
        sweep_on_next    = sweep_on_reg;
        reached_top_next = reached_top_reg;
        delay_left_next  = delay_left_reg;
        red_on_next      = red_on_reg;
        blue_on_next     = blue_on_reg;

        if (advance)
        begin
            case (func_reg)
                FUNC_CAPTURE:
                begin
                    if (!level_reg)
                    begin
                        if (!sitting_reg)
                        begin
                            sitting_next     = 1'b1;
                            sit_start_next   = time_reg;
                            red_on_next      = 1'b0;
                            blue_on_next     = 1'b0;
                            sweep_on_next    = 1'b0;
                            reached_top_next = 1'b0;
                            delay_left_next  = '0;
                        end
                    end
                    else if (sitting_reg)
                    begin
                        sitting_next = 1'b0;
                        red_on_next  = 1'b1;
                        if (elapsed >= 17'(threshold_reg))
                        begin
                            blue_on_next     = 1'b1;
                            angle_next       = '0;
                            moving_down_next = 1'b0;
                            reached_top_next = 1'b0;
                            sweep_on_next    = 1'b0;
                            delay_left_next  = delay_cfg_reg;
                        end
                        else
                        begin
                            blue_on_next     = 1'b0;
                            sweep_on_next    = 1'b0;
                            reached_top_next = 1'b0;
                            delay_left_next  = '0;
                        end
                    end
                end
                FUNC_OVERCAP:
                begin
                    sitting_next     = 1'b0;
                    blue_on_next     = 1'b0;
                    red_on_next      = 1'b1;
                    sweep_on_next    = 1'b0;
                    reached_top_next = 1'b0;
                    delay_left_next  = '0;
                end
                FUNC_TICK:
                begin
                    // countdown to the sweep start
                    if (!sweep_on_reg && delay_left_reg != '0)
                    begin
                        delay_left_next = delay_left_reg - 1'b1;
                        if (delay_left_next == '0)
                        begin
                            angle_next       = '0;
                            moving_down_next = 1'b0;
                            reached_top_next = 1'b0;
                            sweep_on_next    = 1'b1;
                        end
                    end
                    // one degree step
                    if (sweep_on_next)
                    begin
                        if (!moving_down_next)
                        begin
                            if (angle_next + 1'b1 >= ANGLE_MAX)
                            begin
                                angle_next       = ANGLE_MAX;
                                moving_down_next = 1'b1;
                                reached_top_next = 1'b1;
                            end
                            else
                                angle_next = angle_next + 1'b1;
                        end
                        else if (angle_next <= 8'd1)
                        begin
                            angle_next = '0;
                            if (reached_top_next)
                                sweep_on_next = 1'b0;
                            else
                                moving_down_next = 1'b0;
                        end
                        else
                            angle_next = angle_next - 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sitting_reg     <= 1'b0;
            sit_start_reg   <= '0;
            angle_reg       <= '0;
            moving_down_reg <= 1'b0;
            sweep_on_reg    <= 1'b0;
            reached_top_reg <= 1'b0;
            delay_left_reg  <= '0;
            red_on_reg      <= 1'b0;
            blue_on_reg     <= 1'b0;
        end
        else
        begin
            sitting_reg     <= sitting_next;
            sit_start_reg   <= sit_start_next;
            angle_reg       <= angle_next;
            moving_down_reg <= moving_down_next;
            sweep_on_reg    <= sweep_on_next;
            reached_top_reg <= reached_top_next;
            delay_left_reg  <= delay_left_next;
            red_on_reg      <= red_on_next;
            blue_on_reg     <= blue_on_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_red_reg     <= red_on_next;
            out_blue_reg    <= blue_on_next;
            out_angle_reg   <= angle_next;
            out_sweep_reg   <= sweep_on_next;
            out_sitting_reg <= sitting_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign red_led      = out_red_reg;
    assign blue_led     = out_blue_reg;
    assign pulse_width  = pulse_of(out_angle_reg);
    assign sweep_active = out_sweep_reg;
    assign occupied     = out_sitting_reg;

endmodule

### rtl/otss_checker.sv
// port level checks for the servo sweep block and their binding
module otss_checker
    import otss_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic               red_led,
    input logic               blue_led,
    input logic [PULSE_W-1:0] pulse_width,
    input logic               sweep_active,
    input logic               occupied
);

    // a held result keeps its pulse width, sweep and occupied flags
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pulse_width)
            && $stable(sweep_active) && $stable(occupied))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pulse_width >= PULSE_MIN && pulse_width <= PULSE_MAX)
        else $error("pulse width out of range");

    // a sit clears both leds and cancels any sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && occupied |-> !red_led && !blue_led && !sweep_active)
        else $error("seat occupied with leds or sweep on");

    // a sweep only follows a valid long sit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sweep_active |-> blue_led && red_led)
        else $error("sweep without valid stand");

endmodule

bind occupancy_timed_servo_sweep_core otss_checker u_otss_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .red_led      (red_led),
    .blue_led     (blue_led),
    .pulse_width  (pulse_width),
    .sweep_active (sweep_active),
    .occupied     (occupied)
);

### tb/sv/tb_occupancy_timed_servo_sweep_core.sv
// self-checking testbench for the seat occupancy timer with delayed servo sweep
`timescale 1ns / 1ps

module tb_occupancy_timed_servo_sweep_core;
    import otss_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED   = 2'd3;
    localparam logic              LEVEL_SEATED  = 1'b0;
    localparam logic              LEVEL_EMPTY   = 1'b1;
    localparam int unsigned       SWEEP_TOP_DEG = 180;
    localparam int unsigned       REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [TIME_W-1:0] capture_time;
        logic              sensor_level;
    } seat_event_t;

    typedef struct packed {
        logic               red_led;
        logic               blue_led;
        logic [PULSE_W-1:0] pulse_width;
        logic               sweep_active;
        logic               occupied;
    } seat_status_t;

    typedef enum logic [1:0] {READY_ALWAYS, READY_COIN, READY_BURSTY} ready_mode_t;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               in_valid     = 1'b0;
    logic               in_ready;
    logic [FUNC_W-1:0]  func         = FUNC_CAPTURE;
    logic [TIME_W-1:0]  capture_time = '0;
    logic               sensor_level = 1'b0;
    logic               out_valid;
    logic               out_ready    = 1'b0;
    logic               red_led;
    logic               blue_led;
    logic [PULSE_W-1:0] pulse_width;
    logic               sweep_active;
    logic               occupied;
    logic               cfg_valid    = 1'b0;
    logic               cfg_ready;
    logic [CIDX_W-1:0]  cfg_index    = CFG_THRESHOLD;
    logic [CFG_W-1:0]   cfg_data     = '0;

    // predicted register file and block state
    logic [CFG_W-1:0]   sit_threshold   = THRESHOLD_RST;
    logic [CFG_W-1:0]   flush_delay     = DELAY_RST;
    logic [CFG_W-1:0]   ts_top          = TOP_RST;
    logic               seat_taken      = 1'b0;
    logic [TIME_W-1:0]  sit_start_ts    = '0;
    logic [ANGLE_W-1:0] servo_deg       = '0;
    logic               going_down      = 1'b0;
    logic               sweeping        = 1'b0;
    logic               top_reached     = 1'b0;
    logic [CFG_W-1:0]   flush_countdown = '0;
    logic               red_lit         = 1'b0;
    logic               blue_lit        = 1'b0;

    seat_event_t  pending_events[$];
    seat_status_t expected_status[$];

    int unsigned events_queued   = 0;
    int unsigned events_sent     = 0;
    int unsigned results_checked = 0;
    int unsigned sweeps_done     = 0;
    int unsigned long_sits       = 0;
    int unsigned settings_count  = 0;
    int unsigned mismatch_count  = 0;
    int unsigned error_count     = 0;

    logic        hold_off   = 1'b0;
    int unsigned burst_left = 8;
    int unsigned gap_left   = 0;

    ready_mode_t ready_mode = READY_ALWAYS;
    int unsigned mode_left  = 0;
    int unsigned stall_left = 0;

    occupancy_timed_servo_sweep_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .capture_time (capture_time),
        .sensor_level (sensor_level),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .red_led      (red_led),
        .blue_led     (blue_led),
        .pulse_width  (pulse_width),
        .sweep_active (sweep_active),
        .occupied     (occupied),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic void cancel_flush();
        sweeping        = 1'b0;
        top_reached     = 1'b0;
        flush_countdown = '0;
    endfunction

    function automatic void servo_tick();
        if (!sweeping && flush_countdown != 0)
        begin
            flush_countdown = flush_countdown - 1'b1;
            if (flush_countdown == 0)
            begin
                servo_deg   = '0;
                going_down  = 1'b0;
                top_reached = 1'b0;
                sweeping    = 1'b1;
            end
        end
        if (sweeping)
        begin
            if (!going_down)
            begin
                servo_deg = servo_deg + 1'b1;
                if (servo_deg >= ANGLE_MAX)
                begin
                    servo_deg   = ANGLE_MAX;
                    going_down  = 1'b1;
                    top_reached = 1'b1;
                end
            end
            else if (servo_deg <= 1)
            begin
                servo_deg = '0;
                if (top_reached)
                begin
                    sweeping = 1'b0;
                    sweeps_done++;
                end
                else
                    going_down = 1'b0;
            end
            else
                servo_deg = servo_deg - 1'b1;
        end
    endfunction

    function automatic seat_status_t advance_seat_model(seat_event_t ev);
        seat_status_t st;
        int unsigned  elapsed;
        int unsigned  wrapped;
        int unsigned  deg;
        case (ev.func)
            FUNC_CAPTURE:
            begin
                if (ev.sensor_level == LEVEL_SEATED)
                begin
                    if (!seat_taken)
                    begin
                        seat_taken   = 1'b1;
                        sit_start_ts = ev.capture_time;
                        red_lit      = 1'b0;
                        blue_lit     = 1'b0;
                        cancel_flush();
                    end
                end
                else if (seat_taken)
                begin
                    seat_taken = 1'b0;
                    if (ev.capture_time >= sit_start_ts)
                        elapsed = 32'(ev.capture_time) - 32'(sit_start_ts);
                    else
                    begin
                        wrapped = 32'(ts_top) + 32'd1 + 32'(ev.capture_time);
                        elapsed = (wrapped >= 32'(sit_start_ts)) ?
                                  wrapped - 32'(sit_start_ts) : 0;
                    end
                    red_lit = 1'b1;
                    if (elapsed >= 32'(sit_threshold))
                    begin
                        blue_lit        = 1'b1;
                        servo_deg       = '0;
                        going_down      = 1'b0;
                        top_reached     = 1'b0;
                        sweeping        = 1'b0;
                        flush_countdown = flush_delay;
                        long_sits++;
                    end
                    else
                    begin
                        blue_lit = 1'b0;
                        cancel_flush();
                    end
                end
            end
            FUNC_OVERCAP:
            begin
                seat_taken = 1'b0;
                blue_lit   = 1'b0;
                red_lit    = 1'b1;
                cancel_flush();
            end
            FUNC_TICK:
                servo_tick();
            default:
                ;
        endcase
        deg             = (servo_deg > ANGLE_MAX) ? SWEEP_TOP_DEG : 32'(servo_deg);
        st.red_led      = red_lit;
        st.blue_led     = blue_lit;
        st.pulse_width  = PULSE_W'(32'd1000 + (deg * 32'd1000) / SWEEP_TOP_DEG);
        st.sweep_active = sweeping;
        st.occupied     = seat_taken;
        return st;
    endfunction

    // driver: bursts of transfers separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        seat_event_t taken;
        logic        fire;
        logic        next_valid;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            fire       = in_valid && in_ready;
            next_valid = 1'b0;
            if (fire)
            begin
                taken.func         = func;
                taken.capture_time = capture_time;
                taken.sensor_level = sensor_level;
                void'(pending_events.pop_front());
                expected_status.push_back(advance_seat_model(taken));
                events_sent++;
            end
            if (in_valid && !fire)
                next_valid = 1'b1;
            else if (hold_off || pending_events.size() == 0)
                next_valid = 1'b0;
            else if (gap_left != 0)
                gap_left--;
            else
            begin
                next_valid = 1'b1;
                func         <= pending_events[0].func;
                capture_time <= pending_events[0].capture_time;
                sensor_level <= pending_events[0].sensor_level;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            in_valid <= next_valid;
        end
    end

    // monitor: compares each result transfer with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : check_proc
        seat_status_t got;
        seat_status_t want;
        logic         next_ready;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got.red_led      = red_led;
                got.blue_led     = blue_led;
                got.pulse_width  = pulse_width;
                got.sweep_active = sweep_active;
                got.occupied     = occupied;
                results_checked++;
                if (expected_status.size() == 0)
                begin
                    mismatch_count++;
                    error_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: result with nothing expected: ", $realtime,
                                 "red %0b blue %0b pulse %0d sweep %0b occ %0b",
                                 got.red_led, got.blue_led, got.pulse_width,
                                 got.sweep_active, got.occupied);
                end
                else
                begin
                    want = expected_status.pop_front();
                    if (got.red_led !== want.red_led || got.blue_led !== want.blue_led ||
                        got.pulse_width !== want.pulse_width ||
                        got.sweep_active !== want.sweep_active ||
                        got.occupied !== want.occupied)
                    begin
                        mismatch_count++;
                        error_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("%0t: result %0d ", $realtime, results_checked,
                                     "exp red %0b blue %0b pulse %0d sweep %0b occ %0b, ",
                                     want.red_led, want.blue_led, want.pulse_width,
                                     want.sweep_active, want.occupied,
                                     "got red %0b blue %0b pulse %0d sweep %0b occ %0b",
                                     got.red_led, got.blue_led, got.pulse_width,
                                     got.sweep_active, got.occupied);
                    end
                end
            end
            if (mode_left == 0)
            begin
                ready_mode = ready_mode_t'($urandom_range(0, 2));
                mode_left  = $urandom_range(20, 200);
            end
            else
                mode_left--;
            case (ready_mode)
                READY_ALWAYS:
                    next_ready = 1'b1;
                READY_COIN:
                    next_ready = 1'($urandom_range(0, 1));
                default:
                begin
                    if (stall_left != 0)
                    begin
                        stall_left--;
                        next_ready = 1'b0;
                    end
                    else if ($urandom_range(0, 15) == 0)
                    begin
                        stall_left = $urandom_range(1, 20);
                        next_ready = 1'b0;
                    end
                    else
                        next_ready = 1'b1;
                end
            endcase
            out_ready <= next_ready;
        end
    end

    function automatic void push_event(logic [FUNC_W-1:0] f, logic [TIME_W-1:0] t, logic lvl);
        seat_event_t ev;
        ev.func         = f;
        ev.capture_time = t;
        ev.sensor_level = lvl;
        pending_events.push_back(ev);
        events_queued++;
    endfunction

    function automatic void push_ticks(int unsigned run);
        for (int unsigned i = 0; i < run; i++)
            push_event(FUNC_TICK, TIME_W'($urandom), 1'($urandom));
    endfunction

    // mostly complete sit and stand sequences, with noise and broken ones mixed in
    function automatic void queue_random_events(int unsigned count);
        int unsigned base;
        int unsigned span;
        int unsigned t0;
        int unsigned dur;
        int unsigned pick;
        base = events_queued;
        span = 32'(ts_top) + 1;
        while (events_queued - base < count)
        begin
            pick = $urandom_range(0, 11);
            if (pick < 7)
            begin
                t0 = $urandom_range(0, span - 1);
                case ($urandom_range(0, 3))
                    0:       dur = 32'(sit_threshold) + $urandom_range(0, 20);
                    1:       dur = (sit_threshold == 0) ? 0 : 32'(sit_threshold) - 1;
                    default: dur = $urandom_range(0, span - 1);
                endcase
                if (dur > span - 1)
                    dur = span - 1;
                push_event(FUNC_CAPTURE, TIME_W'(t0), LEVEL_SEATED);
                if ($urandom_range(0, 5) == 0)
                    push_event(FUNC_CAPTURE, TIME_W'($urandom), LEVEL_SEATED);
                if ($urandom_range(0, 9) == 0)
                    push_event(FUNC_OVERCAP, TIME_W'($urandom), 1'($urandom));
                push_event(FUNC_CAPTURE, TIME_W'((t0 + dur) % span), LEVEL_EMPTY);
                push_ticks(($urandom_range(0, 9) == 0) ? $urandom_range(360, 400) :
                           $urandom_range(0, 30));
            end
            else if (pick == 7)
                push_event(FUNC_OVERCAP, TIME_W'($urandom), 1'($urandom));
            else if (pick == 8)
                push_event(FUNC_UNUSED, TIME_W'($urandom), 1'($urandom));
            else if (pick < 11)
                push_event(FUNC_CAPTURE, TIME_W'($urandom), 1'($urandom));
            else
                push_ticks($urandom_range(1, 10));
        end
    endfunction

    task automatic wait_drained();
        while (pending_events.size() != 0 || in_valid || expected_status.size() != 0)
            @(negedge clk);
    endtask

    task automatic apply_settings(logic [CFG_W-1:0] thr, logic [CFG_W-1:0] dly,
                                  logic [CFG_W-1:0] top);
        logic [CIDX_W-1:0] idx [3];
        logic [CFG_W-1:0]  val [3];
        idx[0] = CFG_THRESHOLD;
        idx[1] = CFG_DELAY;
        idx[2] = CFG_TOP;
        val[0] = thr;
        val[1] = dly;
        val[2] = top;
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx[0];
        cfg_data  <= val[0];
        for (int i = 0; i < 3; i++)
        begin
            @(posedge clk);
            while (!(cfg_valid && cfg_ready))
                @(posedge clk);
            case (cfg_index)
                CFG_THRESHOLD: sit_threshold = cfg_data;
                CFG_DELAY:     flush_delay   = cfg_data;
                CFG_TOP:       ts_top        = cfg_data;
                default:       ;
            endcase
            if (i < 2)
            begin
                cfg_index <= idx[i+1];
                cfg_data  <= val[i+1];
            end
        end
        cfg_valid <= 1'b0;
        settings_count++;
        @(negedge clk);
    endtask

    initial
    begin
        #(5_000_000);
        $display("timeout: %0d results still expected", expected_status.size());
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin : stimulus_proc
        int unsigned half_mark;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // repeated edges, wrap of the counter, cancelled flush and overcapture
        apply_settings(16'd100, 16'd2, 16'hFFFF);
        push_event(FUNC_UNUSED, 16'hFFFF, LEVEL_EMPTY);
        push_event(FUNC_CAPTURE, 16'h0000, LEVEL_EMPTY);
        push_event(FUNC_CAPTURE, 16'hFFF0, LEVEL_SEATED);
        push_event(FUNC_CAPTURE, 16'h0005, LEVEL_SEATED);
        push_event(FUNC_CAPTURE, 16'h0010, LEVEL_EMPTY);
        push_event(FUNC_CAPTURE, 16'h0000, LEVEL_SEATED);
        push_event(FUNC_CAPTURE, 16'hFFFF, LEVEL_EMPTY);
        push_ticks(5);
        push_event(FUNC_CAPTURE, 16'd100, LEVEL_SEATED);
        push_event(FUNC_CAPTURE, 16'd150, LEVEL_EMPTY);
        push_event(FUNC_CAPTURE, 16'd200, LEVEL_SEATED);
        push_event(FUNC_CAPTURE, 16'd400, LEVEL_EMPTY);
        push_event(FUNC_OVERCAP, 16'hFFFF, LEVEL_EMPTY);
        push_event(FUNC_TICK, 16'h0000, LEVEL_SEATED);
        wait_drained();

        // end time wraps but stays below the start: elapsed saturates at zero
        apply_settings(16'd1, 16'd1, 16'd10);
        push_event(FUNC_CAPTURE, 16'd500, LEVEL_SEATED);
        push_event(FUNC_CAPTURE, 16'd3, LEVEL_EMPTY);
        wait_drained();
        apply_settings(16'd0, 16'd0, 16'd10);
        push_event(FUNC_CAPTURE, 16'd500, LEVEL_SEATED);
        push_event(FUNC_CAPTURE, 16'd3, LEVEL_EMPTY);
        push_event(FUNC_TICK, 16'd0, LEVEL_EMPTY);
        wait_drained();

        // one guaranteed full sweep, then random traffic
        apply_settings(16'd0, 16'd1, 16'hFFFF);
        push_event(FUNC_CAPTURE, 16'h1234, LEVEL_SEATED);
        push_event(FUNC_CAPTURE, 16'h5678, LEVEL_EMPTY);
        push_ticks(370);
        queue_random_events(60);
        wait_drained();

        apply_settings(16'hFFFF, 16'hFFFF, 16'd1);
        queue_random_events(120);
        wait_drained();

        apply_settings(16'($urandom_range(0, 400)), 16'($urandom_range(1, 6)),
                       16'($urandom_range(1000, 65535)));
        queue_random_events(150);
        wait_drained();

        // register defaults, with the sender held off until the block drains
        apply_settings(THRESHOLD_RST, DELAY_RST, TOP_RST);
        queue_random_events(150);
        half_mark = pending_events.size() / 2;
        while (pending_events.size() > half_mark)
            @(negedge clk);
        hold_off = 1'b1;
        while (in_valid || expected_status.size() != 0)
            @(negedge clk);
        hold_off = 1'b0;
        wait_drained();

        apply_settings(16'($urandom), 16'($urandom_range(0, 4)), 16'($urandom_range(1, 65535)));
        queue_random_events(150);
        wait_drained();

        apply_settings(16'($urandom), 16'd1, 16'hFFFF);
        queue_random_events(120);
        wait_drained();

        repeat (8) @(posedge clk);
        if (expected_status.size() != 0)
        begin
            error_count++;
            $display("%0d expected results never arrived", expected_status.size());
        end
        $display("covered %0d events under %0d register settings, %0d results checked",
                 events_sent, settings_count, results_checked);
        $display("%0d long sits and %0d complete sweeps seen, %0d mismatches",
                 long_sits, sweeps_done, mismatch_count);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### filelist.f
rtl/otss_pkg.sv
rtl/occupancy_timed_servo_sweep_core.sv
rtl/otss_checker.sv
tb/sv/tb_occupancy_timed_servo_sweep_core.sv
